// ----- hw/rtl/sra_pkg.sv -----
`default_nettype none

package sra_pkg;

   localparam int PAGES_DEF       = 64;
   localparam int PAGE_WIDTH_DEF  = 128;
   localparam int PAGE_HEIGHT_DEF = 128;

   localparam int KIND_W   = 1;
   localparam int RECT_W   = 8;
   localparam int STATUS_W = 1;
   localparam int PAGE_W   = 6;
   localparam int POS_W    = 7;

   localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 1'b0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PAGE,
      ST_SCAN,
      ST_WRITE,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/skyline_rect_allocator_top.sv -----
// Skyline rectangle allocator.
// The req channel carries one item: req_kind selects an allocation of a
// req_rect_width by req_rect_height rectangle or a clear of all column heights.
// Every item yields exactly one rsp item with status, page, pos_x and pos_y.
// Column heights live in one single-port memory of PAGES * PAGE_WIDTH entries
// that is read one column per cycle with a registered read.
// An allocation walks the pages in order; each page takes a start step and then
// between PAGE_WIDTH - width and about (PAGE_WIDTH - width) * width column reads,
// since a failed window resumes past the column that failed it and a successful
// one resumes past its tallest column. A placement then writes width columns
// at one per cycle, and the response is loaded into the output register once
// that register is free. A full search costs about PAGES scans.
// A clear item and reset both run a clearing pass over all PAGES * PAGE_WIDTH
// memory entries; req_stall stays high during the pass and any search.
// A result sits in an output register, so the next item is accepted while it
// waits; when rsp_stall holds the register, a finished search waits for it.
`default_nettype none

module skyline_rect_allocator_top #(
   parameter int PAGES       = sra_pkg::PAGES_DEF,
   parameter int PAGE_WIDTH  = sra_pkg::PAGE_WIDTH_DEF,
   parameter int PAGE_HEIGHT = sra_pkg::PAGE_HEIGHT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [sra_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [sra_pkg::RECT_W-1:0]      req_rect_width,
   input  wire logic [sra_pkg::RECT_W-1:0]      req_rect_height,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [sra_pkg::STATUS_W-1:0]         rsp_status,
   output logic [sra_pkg::PAGE_W-1:0]           rsp_page,
   output logic [sra_pkg::POS_W-1:0]            rsp_pos_x,
   output logic [sra_pkg::POS_W-1:0]            rsp_pos_y
);

   localparam int DEPTH = PAGES * PAGE_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int CW    = $clog2(PAGE_WIDTH) + 1;
   localparam int HW    = $clog2(PAGE_HEIGHT + 1);
   localparam int SW    = ((HW > sra_pkg::RECT_W) ? HW : sra_pkg::RECT_W) + 1;

   sra_pkg::state_type state_ff, state_in;

   logic [HW-1:0] mem [DEPTH];
   logic [HW-1:0] rdata_ff;
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic [HW-1:0] mem_wdata;

   logic [PGW-1:0]              pg_ff, pg_in;
   logic [AW-1:0]               base_ff, base_in;
   logic [CW-1:0]               st_ff, st_in;
   logic [CW-1:0]               c_ff, c_in;
   logic [CW-1:0]               pmax_ff, pmax_in;
   logic [CW-1:0]               sx_ff, sx_in;
   logic [CW-1:0]               w_ff, w_in;
   logic [sra_pkg::RECT_W-1:0]  h_ff, h_in;
   logic [HW-1:0]               best_ff, best_in;
   logic [HW-1:0]               top_ff, top_in;
   logic                        found_ff, found_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic                        clr_resp_ff, clr_resp_in;
   logic                        full_ff, full_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sra_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [sra_pkg::PAGE_W-1:0]  rsp_page_ff, rsp_page_in;
   logic [sra_pkg::POS_W-1:0]   rsp_pos_x_ff, rsp_pos_x_in;
   logic [sra_pkg::POS_W-1:0]   rsp_pos_y_ff, rsp_pos_y_in;

   logic          req_acc;
   logic          req_too_wide;
   logic          req_zero_w;
   logic          req_h_over;
   logic          out_free;
   logic          col_fail;
   logic          col_ge_top;
   logic [HW-1:0] top_nx;
   logic [CW-1:0] pmax_nx;
   logic [CW-1:0] win_end;
   logic          win_done;
   logic          win_close;
   logic [CW-1:0] st_nx;
   logic [CW-1:0] limit;
   logic          page_end;
   logic          found_nx;
   logic [HW-1:0] best_nx;
   logic [CW-1:0] sx_nx;
   logic [SW-1:0] level_sum;
   logic          page_fit;
   logic          last_page;
   logic [CW-1:0] wr_end;
   logic [31:0]   pg_wide;
   logic [31:0]   sx_wide;
   logic [31:0]   best_wide;

   assign req_stall = (state_ff != sra_pkg::ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_too_wide = {1'b0, req_rect_width} >= (sra_pkg::RECT_W + 1)'(PAGE_WIDTH);
   assign req_zero_w   = (req_rect_width == '0);
   assign req_h_over   = {1'b0, req_rect_height} > (sra_pkg::RECT_W + 1)'(PAGE_HEIGHT);

   assign col_fail   = (rdata_ff >= best_ff);
   assign col_ge_top = (rdata_ff >= top_ff);
   assign top_nx     = col_ge_top ? rdata_ff : top_ff;
   assign pmax_nx    = col_ge_top ? c_ff : pmax_ff;
   assign win_end    = st_ff + w_ff - CW'(1);
   assign win_done   = (c_ff == win_end);
   assign win_close  = col_fail || win_done;
   assign st_nx      = col_fail ? (c_ff + CW'(1)) : (pmax_nx + CW'(1));
   assign limit      = CW'(PAGE_WIDTH) - w_ff;
   assign page_end   = win_close && (st_nx >= limit);
   assign found_nx   = found_ff || (win_done && !col_fail);
   assign best_nx    = (win_done && !col_fail) ? top_nx : best_ff;
   assign sx_nx      = (win_done && !col_fail) ? st_ff : sx_ff;
   assign level_sum  = SW'(best_nx) + SW'(h_ff);
   assign page_fit   = level_sum <= SW'(PAGE_HEIGHT);
   assign last_page  = (pg_ff == PGW'(PAGES - 1));
   assign wr_end     = sx_ff + w_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_addr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sra_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = clr_resp_ff ? sra_pkg::ST_RESP : sra_pkg::ST_IDLE;
            end
         end
         sra_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_kind == sra_pkg::KIND_CLEAR) begin
                  state_in = sra_pkg::ST_CLEAR;
               end else if (req_too_wide || req_zero_w) begin
                  state_in = sra_pkg::ST_RESP;
               end else begin
                  state_in = sra_pkg::ST_PAGE;
               end
            end
         end
         sra_pkg::ST_PAGE: begin
            state_in = sra_pkg::ST_SCAN;
         end
         sra_pkg::ST_SCAN: begin
            if (page_end) begin
               if (found_nx && page_fit) begin
                  state_in = sra_pkg::ST_WRITE;
               end else if (last_page) begin
                  state_in = sra_pkg::ST_RESP;
               end else begin
                  state_in = sra_pkg::ST_PAGE;
               end
            end
         end
         sra_pkg::ST_WRITE: begin
            if (c_ff == wr_end) begin
               state_in = sra_pkg::ST_RESP;
            end
         end
         sra_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = sra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sra_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pg_in         = pg_ff;
      base_in       = base_ff;
      st_in         = st_ff;
      c_in          = c_ff;
      pmax_in       = pmax_ff;
      sx_in         = sx_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      best_in       = best_ff;
      top_in        = top_ff;
      found_in      = found_ff;
      clr_in        = clr_ff;
      clr_resp_in   = clr_resp_ff;
      full_in       = full_ff;
      mem_addr      = '0;
      mem_we        = 1'b0;
      mem_wdata     = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_pos_x_in  = rsp_pos_x_ff;
      rsp_pos_y_in  = rsp_pos_y_ff;
      pg_wide       = 32'(pg_ff);
      sx_wide       = 32'(sx_ff);
      best_wide     = 32'(best_ff);
      unique case (state_ff)
         sra_pkg::ST_CLEAR: begin
            mem_addr = clr_ff;
            mem_we   = 1'b1;
            clr_in   = clr_ff + AW'(1);
            pg_in    = '0;
            sx_in    = '0;
            best_in  = '0;
            full_in  = 1'b0;
         end
         sra_pkg::ST_IDLE: begin
            if (req_acc) begin
               w_in    = CW'(req_rect_width);
               h_in    = req_rect_height;
               pg_in   = '0;
               base_in = '0;
               sx_in   = '0;
               best_in = '0;
               clr_in  = '0;
               if (req_kind == sra_pkg::KIND_CLEAR) begin
                  clr_resp_in = 1'b1;
               end else if (req_too_wide) begin
                  full_in = 1'b1;
               end else begin
                  full_in = req_zero_w && req_h_over;
               end
            end
         end
         sra_pkg::ST_PAGE: begin
            mem_addr = base_ff;
            st_in    = '0;
            c_in     = '0;
            top_in   = '0;
            pmax_in  = '0;
            best_in  = HW'(PAGE_HEIGHT);
            found_in = 1'b0;
         end
         sra_pkg::ST_SCAN: begin
            if (win_close) begin
               mem_addr = base_ff + AW'(st_nx);
               best_in  = best_nx;
               sx_in    = sx_nx;
               found_in = found_nx;
               st_in    = st_nx;
               c_in     = st_nx;
               top_in   = '0;
               if (page_end) begin
                  if (found_nx && page_fit) begin
                     c_in = sx_nx;
                  end else if (last_page) begin
                     full_in = 1'b1;
                     pg_in   = '0;
                     sx_in   = '0;
                     best_in = '0;
                  end else begin
                     pg_in   = pg_ff + PGW'(1);
                     base_in = base_ff + AW'(PAGE_WIDTH);
                  end
               end
            end else begin
               mem_addr = base_ff + AW'(c_ff + CW'(1));
               c_in     = c_ff + CW'(1);
               top_in   = top_nx;
               pmax_in  = pmax_nx;
            end
         end
         sra_pkg::ST_WRITE: begin
            mem_addr  = base_ff + AW'(c_ff);
            mem_we    = 1'b1;
            mem_wdata = HW'(SW'(best_ff) + SW'(h_ff));
            c_in      = c_ff + CW'(1);
         end
         sra_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = full_ff ? sra_pkg::STATUS_FULL : sra_pkg::STATUS_OK;
               rsp_page_in   = pg_wide[sra_pkg::PAGE_W-1:0];
               rsp_pos_x_in  = sx_wide[sra_pkg::POS_W-1:0];
               rsp_pos_y_in  = best_wide[sra_pkg::POS_W-1:0];
               clr_resp_in   = 1'b0;
            end
         end
         default: begin
            mem_addr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sra_pkg::ST_CLEAR;
         clr_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         full_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_resp_ff  <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         full_ff      <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      pg_ff         <= pg_in;
      base_ff       <= base_in;
      st_ff         <= st_in;
      c_ff          <= c_in;
      pmax_ff       <= pmax_in;
      sx_ff         <= sx_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      best_ff       <= best_in;
      top_ff        <= top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_pos_x_ff  <= rsp_pos_x_in;
      rsp_pos_y_ff  <= rsp_pos_y_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_page   = rsp_page_ff;
   assign rsp_pos_x  = rsp_pos_x_ff;
   assign rsp_pos_y  = rsp_pos_y_ff;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;

   localparam int HOLD_CYCLES = 2000;
   localparam int SETTLE_CYCLES = 40;

   typedef logic [sra_pkg::KIND_W-1:0] kind_type;
   typedef logic [sra_pkg::RECT_W-1:0] rect_type;

   typedef struct packed {
      logic [sra_pkg::STATUS_W-1:0] status;
      logic [sra_pkg::PAGE_W-1:0]   page;
      logic [sra_pkg::POS_W-1:0]    pos_x;
      logic [sra_pkg::POS_W-1:0]    pos_y;
   } placement_type;

   class placement_board_type;
      int col_height[sra_pkg::PAGES_DEF][sra_pkg::PAGE_WIDTH_DEF];
      placement_type placements_due[$];
      int errors;
      int requests;
      int clears;
      int fulls;
      int placed;
      int top_page;
      int checked;

      function placement_type place_rect(kind_type kind, rect_type w_in, rect_type h_in);
         placement_type res;
         int wi;
         int hi;
         int best;
         int top;
         int start;
         int v;
         bit found;
         bit fits;
         res = '0;
         res.status = sra_pkg::STATUS_OK;
         wi = int'(w_in);
         hi = int'(h_in);
         if (kind == sra_pkg::KIND_CLEAR) begin
            foreach (col_height[p, c]) col_height[p][c] = 0;
            return res;
         end
         for (int pg = 0; pg < sra_pkg::PAGES_DEF; pg++) begin
            best = sra_pkg::PAGE_HEIGHT_DEF;
            found = 0;
            start = 0;
            if (wi < sra_pkg::PAGE_WIDTH_DEF) begin
               for (int s = 0; s < sra_pkg::PAGE_WIDTH_DEF - wi; s++) begin
                  top = 0;
                  fits = 1;
                  for (int j = 0; j < wi; j++) begin
                     v = col_height[pg][s + j];
                     if (v >= best) begin
                        fits = 0;
                        break;
                     end
                     if (v > top) top = v;
                  end
                  if (fits && top < best) begin
                     best = top;
                     start = s;
                     found = 1;
                  end
               end
            end
            if (found && best + hi <= sra_pkg::PAGE_HEIGHT_DEF) begin
               for (int j = 0; j < wi; j++) col_height[pg][start + j] = best + hi;
               res.page = (sra_pkg::PAGE_W)'(pg);
               res.pos_x = (sra_pkg::POS_W)'(start);
               res.pos_y = (sra_pkg::POS_W)'(best);
               return res;
            end
         end
         res.status = sra_pkg::STATUS_FULL;
         return res;
      endfunction

      function void note_request(kind_type kind, rect_type w_in, rect_type h_in);
         placement_type res;
         res = place_rect(kind, w_in, h_in);
         requests++;
         if (kind == sra_pkg::KIND_CLEAR) begin
            clears++;
         end else if (res.status == sra_pkg::STATUS_FULL) begin
            fulls++;
         end else begin
            placed++;
            if (res.page > top_page) top_page = int'(res.page);
         end
         placements_due.push_back(res);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) $display("ERROR: %s", what);
      endtask

      task check_placement(logic [sra_pkg::STATUS_W-1:0] status,
                           logic [sra_pkg::PAGE_W-1:0] page,
                           logic [sra_pkg::POS_W-1:0] pos_x,
                           logic [sra_pkg::POS_W-1:0] pos_y);
         placement_type want;
         if (placements_due.size() == 0) begin
            report($sformatf("result with no request waiting: status %0d page %0d x %0d y %0d",
                             status, page, pos_x, pos_y));
            return;
         end
         want = placements_due.pop_front();
         checked++;
         if (status !== want.status)
            report($sformatf("result %0d: status %0d, expected %0d", checked, status,
                             want.status));
         if (page !== want.page)
            report($sformatf("result %0d: page %0d, expected %0d", checked, page, want.page));
         if (pos_x !== want.pos_x)
            report($sformatf("result %0d: pos_x %0d, expected %0d", checked, pos_x,
                             want.pos_x));
         if (pos_y !== want.pos_y)
            report($sformatf("result %0d: pos_y %0d, expected %0d", checked, pos_y,
                             want.pos_y));
      endtask
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   kind_type                     req_kind;
   rect_type                     req_rect_width;
   rect_type                     req_rect_height;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [sra_pkg::STATUS_W-1:0] rsp_status;
   logic [sra_pkg::PAGE_W-1:0]   rsp_page;
   logic [sra_pkg::POS_W-1:0]    rsp_pos_x;
   logic [sra_pkg::POS_W-1:0]    rsp_pos_y;

   placement_board_type board = new();

   int burst_left = 0;
   int hold_ask = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int seg_left = 0;
   int stall_pct = 0;

   skyline_rect_allocator_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_page        (rsp_page),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver stalls on random segments of varying density, and holds off
   // for a long stretch whenever the stimulus asks for one.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         board.check_placement(rsp_status, rsp_page, rsp_pos_x, rsp_pos_y);
      if (hold_seen != hold_ask) begin
         hold_seen <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (seg_left == 0) begin
            seg_left <= $urandom_range(1, 80);
            case ($urandom_range(0, 4))
               0, 1: stall_pct <= 0;
               2: stall_pct <= 25;
               3: stall_pct <= 50;
               default: stall_pct <= 90;
            endcase
         end else begin
            seg_left <= seg_left - 1;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_item(input kind_type kind, input rect_type w_in, input rect_type h_in);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_rect_width <= w_in;
      req_rect_height <= h_in;
      do @(posedge clock); while (req_stall);
      board.note_request(kind, w_in, h_in);
   endtask

   task automatic pace_sender;
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 600) : $urandom_range(1, 20);
         req_valid <= 1'b0;
         req_kind <= kind_type'($urandom);
         req_rect_width <= rect_type'($urandom);
         req_rect_height <= rect_type'($urandom);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 6) == 0) ? 30 : $urandom_range(0, 8);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (board.placements_due.size() != 0);
   endtask

   task automatic send_random_item;
      kind_type kind;
      rect_type w_in;
      rect_type h_in;
      int pick;
      kind = ($urandom_range(0, 99) < 3) ? sra_pkg::KIND_CLEAR : sra_pkg::KIND_ALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 3) w_in = '0;
      else if (pick < 70) w_in = rect_type'($urandom_range(1, 24));
      else if (pick < 88) w_in = rect_type'($urandom_range(25, 127));
      else w_in = rect_type'($urandom_range(128, 255));
      pick = $urandom_range(0, 99);
      if (pick < 3) h_in = '0;
      else if (pick < 75) h_in = rect_type'($urandom_range(1, 40));
      else if (pick < 92) h_in = rect_type'($urandom_range(41, 128));
      else h_in = rect_type'($urandom_range(129, 255));
      send_item(kind, w_in, h_in);
      pace_sender();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = sra_pkg::KIND_ALLOC;
      req_rect_width = '0;
      req_rect_height = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(sra_pkg::KIND_ALLOC, 8'd1, 8'd1);     pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd127, 8'd1);   pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd128, 8'd1);   pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd255, 8'd255); pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd0, 8'd5);     pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd0, 8'd200);   pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd4, 8'd0);     pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd10, 8'd128);  pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd1, 8'd129);   pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd64, 8'd128);  pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd2, 8'd127);   pace_sender();
      send_item(sra_pkg::KIND_CLEAR, 8'd255, 8'd255); pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd1, 8'd1);     pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd127, 8'd128); pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd126, 8'd128); pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd255, 8'd0);   pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd128, 8'd0);   pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd0, 8'd0);     pace_sender();
      send_item(sra_pkg::KIND_ALLOC, 8'd1, 8'd128);   pace_sender();
      send_item(sra_pkg::KIND_CLEAR, 8'd0, 8'd0);     pace_sender();
      drain();

      repeat (5) send_random_item();

      // While the receiver holds off, cheap items keep coming until the
      // block backs up and stalls its input.
      hold_ask <= hold_ask + 1;
      repeat (6) send_item(sra_pkg::KIND_ALLOC, rect_type'($urandom_range(1, 8)),
                           rect_type'($urandom_range(1, 4)));
      pace_sender();

      repeat (5) send_random_item();

      // Fill one page per item until every page is full, then ask for more.
      send_item(sra_pkg::KIND_CLEAR, rect_type'($urandom), rect_type'($urandom));
      pace_sender();
      repeat (sra_pkg::PAGES_DEF + 2) begin
         send_item(sra_pkg::KIND_ALLOC, rect_type'($urandom_range(64, 127)), 8'd128);
         pace_sender();
      end
      repeat (3) begin
         send_item(sra_pkg::KIND_ALLOC, rect_type'($urandom_range(1, 20)),
                   rect_type'($urandom_range(1, 10)));
         pace_sender();
      end
      send_item(sra_pkg::KIND_CLEAR, rect_type'($urandom), rect_type'($urandom));
      pace_sender();

      repeat (5) send_random_item();

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d placed, %0d full, %0d clears; %0d results checked.",
               board.requests, board.placed, board.fulls, board.clears, board.checked);
      $display("Highest page used was %0d; %0d mismatches found.", board.top_page,
               board.errors);
      if (board.errors == 0 && board.placements_due.size() == 0) begin
         $display("skyline_rect_allocator_top verification clean");
      end else begin
         $display("skyline_rect_allocator_top verification failed");
      end
      $finish;
   end

   initial begin
      #1000000000;
      $display("Timed out with %0d results still expected.", board.placements_due.size());
      $display("skyline_rect_allocator_top verification failed");
      $finish;
   end

endmodule

`default_nettype wire
